@@ rtl/iredc_pkg.sv @@
// shared types and constants for the ir edge duration capture block
// no dependencies; imported by every module of the block
package iredc_pkg;

  // capture store geometry
  localparam int unsigned BufDepth = 64;
  localparam int unsigned IdxW     = $clog2(BufDepth);
  localparam int unsigned LenW     = IdxW + 1;

  // field widths
  localparam int unsigned TsW      = 32;
  localparam int unsigned DurW     = 16;
  localparam int unsigned TimeoutW = 20;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [TimeoutW-1:0] TimeoutReset = 20'd7800;
  localparam logic [DurW-1:0]     DurMax       = '1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_AUTO    = 1'b1;

  // visible capture state codes
  localparam logic [1:0] CODE_FINISHED = 2'd0;
  localparam logic [1:0] CODE_READY    = 2'd1;
  localparam logic [1:0] CODE_RUNNING  = 2'd2;

  // frame completion reasons
  localparam logic [1:0] REASON_NONE    = 2'd0;
  localparam logic [1:0] REASON_TIMEOUT = 2'd1;
  localparam logic [1:0] REASON_FULL    = 2'd2;

  typedef enum logic [1:0] {
    ACT_EDGE    = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_WANT    = 2'd2,
    ACT_READ    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_FINISHED = 3'b001,
    ST_READY    = 3'b010,
    ST_RUNNING  = 3'b100
  } cap_state_e;

  // one queued input word
  typedef struct packed {
    action_e          action;
    logic [TsW-1:0]   ts;
    logic             pin_high;
    logic [IdxW-1:0]  read_index;
  } item_t;

  // live configuration seen by the back end
  typedef struct packed {
    logic [TimeoutW-1:0] timeout_us;
    logic                auto_resume;
  } cfg_t;

  // registered result word, all but the read data
  typedef struct packed {
    logic             recorded;
    logic [DurW-1:0]  duration;
    logic [IdxW-1:0]  write_index;
    logic             frame_done;
    logic [1:0]       done_reason;
    logic             auto_resumed;
    logic             new_data;
    logic [1:0]       state_code;
    logic [LenW-1:0]  capture_length;
    logic [LenW-1:0]  decode_length;
    logic             is_read;
  } result_t;

endpackage

@@ rtl/iredc_front.sv @@
// front end: accepts input words, decodes the action and queues them
// depends on iredc_pkg
module iredc_front import iredc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      action_i,
  input  logic [TsW-1:0]  timestamp_us_i,
  input  logic            pin_high_i,
  input  logic [IdxW-1:0] read_index_i,
  output logic            q_valid_o,
  output item_t           q_item_o,
  input  logic            q_pop_i
);

  localparam int unsigned Depth = 2;

  item_t       slot_q [Depth];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;
  item_t       in_item;

  // decode the incoming word
  always_comb begin
    in_item.action     = action_e'(action_i);
    in_item.ts         = timestamp_us_i;
    in_item.pin_high   = pin_high_i;
    in_item.read_index = read_index_i;
  end

  assign in_ready_o = (cnt_q != 2'(Depth));
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = slot_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  // pointer and fill count
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue slots
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

@@ rtl/iredc_back.sv @@
// back end: capture state machine, duration store and result register
// depends on iredc_pkg
module iredc_back import iredc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  item_t           q_item_i,
  output logic            q_pop_o,
  input  cfg_t            cfg_i,
  output logic            cfg_restore_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output result_t         res_o,
  output logic [DurW-1:0] read_data_o
);

  cap_state_e      st_q, st_d;
  logic [LenW-1:0] len_q, len_d;
  logic [TsW-1:0]  last_q, last_d;
  logic            wants_q, wants_d;
  logic            rdy_q, rdy_d;
  logic            resumed_q, resumed_d;
  logic [LenW-1:0] declen_q, declen_d;

  logic            out_valid_q, out_valid_d;
  result_t         res_q;
  logic [DurW-1:0] rd_q;
  logic [DurW-1:0] mem [BufDepth];

  logic            exec;
  logic [TsW-1:0]  delta;
  logic [LenW-1:0] base, len_inc;
  logic            take, complete, wr_en;
  logic [DurW-1:0] dur;
  logic [1:0]      reason;
  logic [1:0]      code;

  assign exec    = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = exec;

  assign delta   = q_item_i.ts - last_q;
  assign base    = (len_q >= LenW'(BufDepth)) ? '0 : len_q;
  assign len_inc = base + LenW'(1);
  assign dur     = (delta > TsW'(DurMax)) ? DurMax : delta[DurW-1:0];

  // next capture state for the word at the head of the queue
  always_comb begin
    st_d          = st_q;
    len_d         = len_q;
    last_d        = last_q;
    wants_d       = wants_q;
    rdy_d         = rdy_q;
    resumed_d     = resumed_q;
    declen_d      = declen_q;
    take          = 1'b0;
    complete      = 1'b0;
    wr_en         = 1'b0;
    reason        = REASON_NONE;
    cfg_restore_o = 1'b0;
    unique case (q_item_i.action)
      ACT_EDGE: begin
        unique case (st_q)
          ST_FINISHED: begin
            take = 1'b0;
          end
          ST_READY: begin
            if (!q_item_i.pin_high) begin
              take = 1'b1;
              st_d = ST_RUNNING;
            end
          end
          default: begin
            // running; an even count and a long gap close the frame
            if (!len_q[0] && (delta > TsW'(cfg_i.timeout_us))) begin
              complete = 1'b1;
              reason   = REASON_TIMEOUT;
            end else begin
              take = 1'b1;
            end
          end
        endcase
        if (take) begin
          wr_en  = 1'b1;
          last_d = q_item_i.ts;
          len_d  = len_inc;
          if (len_inc >= LenW'(BufDepth)) begin
            complete = 1'b1;
            reason   = REASON_FULL;
          end
        end
        // frame completion, with optional automatic restart
        if (complete) begin
          rdy_d = 1'b1;
          if (cfg_i.auto_resume && wants_q) begin
            declen_d  = len_d;
            wants_d   = 1'b0;
            resumed_d = 1'b1;
            len_d     = '0;
            st_d      = ST_READY;
          end else begin
            st_d = ST_FINISHED;
          end
        end
      end
      ACT_RESTART: begin
        cfg_restore_o = exec;
        rdy_d         = 1'b0;
        len_d         = '0;
        wants_d       = 1'b1;
        st_d          = ST_READY;
      end
      ACT_WANT: begin
        wants_d = 1'b1;
      end
      ACT_READ: begin
        wants_d = wants_q;
      end
      default: begin
        wants_d = wants_q;
      end
    endcase
  end

  // visible state code
  always_comb begin
    unique case (st_d)
      ST_FINISHED: code = CODE_FINISHED;
      ST_READY:    code = CODE_READY;
      default:     code = CODE_RUNNING;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_FINISHED;
      len_q       <= '0;
      last_q      <= '0;
      wants_q     <= 1'b0;
      rdy_q       <= 1'b0;
      resumed_q   <= 1'b0;
      declen_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (exec) begin
        st_q      <= st_d;
        len_q     <= len_d;
        last_q    <= last_d;
        wants_q   <= wants_d;
        rdy_q     <= rdy_d;
        resumed_q <= resumed_d;
        declen_q  <= declen_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (exec) begin
      res_q.recorded       <= wr_en;
      res_q.duration       <= wr_en ? dur : '0;
      res_q.write_index    <= wr_en ? base[IdxW-1:0] : '0;
      res_q.frame_done     <= complete;
      res_q.done_reason    <= reason;
      res_q.auto_resumed   <= resumed_d;
      res_q.new_data       <= rdy_d;
      res_q.state_code     <= code;
      res_q.capture_length <= len_d;
      res_q.decode_length  <= declen_d;
      res_q.is_read        <= (q_item_i.action == ACT_READ);
    end
  end

  // duration store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (exec && wr_en) begin
      mem[base[IdxW-1:0]] <= dur;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec && (q_item_i.action == ACT_READ)) begin
      rd_q <= mem[q_item_i.read_index];
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign read_data_o = res_q.is_read ? rd_q : '0;

endmodule

@@ rtl/ir_edge_duration_capture.sv @@
// top level of the ir edge duration capture block: config registers and wiring
// depends on iredc_pkg, iredc_front and iredc_back
//
//  channel | signals                                  | role
//  --------+------------------------------------------+-----------------------
//  in      | in_valid_i / in_ready_o + input fields   | edge, restart, want, read
//  out     | out_valid_o / out_ready_i + result fields| one result word per input
//  cfg     | cfg_we_i, cfg_index_i, cfg_data_i        | write-only registers
//
// one word per cycle sustained while out_ready_i stays high; each accepted
// word is written into the queue and executes into the result register once
// it heads the queue and the result register is free or being taken.
// the back end updates the capture state and the store as it executes each word.
// a two-entry queue decouples input acceptance from result stalls.
// reset clears all control state; the duration store is not cleared.
module ir_edge_duration_capture import iredc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          action_i,
  input  logic [TsW-1:0]      timestamp_us_i,
  input  logic                pin_high_i,
  input  logic [IdxW-1:0]     read_index_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                recorded_o,
  output logic [DurW-1:0]     duration_o,
  output logic [IdxW-1:0]     write_index_o,
  output logic                frame_done_o,
  output logic [1:0]          done_reason_o,
  output logic                auto_resumed_o,
  output logic                new_data_o,
  output logic [1:0]          capture_state_out_o,
  output logic [LenW-1:0]     capture_length_out_o,
  output logic [LenW-1:0]     decode_length_out_o,
  output logic [DurW-1:0]     read_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [TimeoutW-1:0] cfg_data_i
);

  cfg_t    cfg_q, cfg_d;
  logic    cfg_restore;
  logic    q_valid, q_pop;
  item_t   q_item;
  result_t res;

  // configuration registers; a restart word restores the reset values
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_restore) begin
      cfg_d.timeout_us  = TimeoutReset;
      cfg_d.auto_resume = 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TIMEOUT: cfg_d.timeout_us  = cfg_data_i;
        CFG_AUTO:    cfg_d.auto_resume = cfg_data_i[0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_us  <= TimeoutReset;
      cfg_q.auto_resume <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  iredc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .timestamp_us_i (timestamp_us_i),
    .pin_high_i     (pin_high_i),
    .read_index_i   (read_index_i),
    .q_valid_o      (q_valid),
    .q_item_o       (q_item),
    .q_pop_i        (q_pop)
  );

  iredc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .cfg_i         (cfg_q),
    .cfg_restore_o (cfg_restore),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .res_o         (res),
    .read_data_o   (read_data_o)
  );

  // result fields
  assign recorded_o           = res.recorded;
  assign duration_o           = res.duration;
  assign write_index_o        = res.write_index;
  assign frame_done_o         = res.frame_done;
  assign done_reason_o        = res.done_reason;
  assign auto_resumed_o       = res.auto_resumed;
  assign new_data_o           = res.new_data;
  assign capture_state_out_o  = res.state_code;
  assign capture_length_out_o = res.capture_length;
  assign decode_length_out_o  = res.decode_length;

endmodule
